@@ sv/sus_pkg.sv @@
package sus_pkg;

    // Table capacity and derived widths.
    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int OUT_CNT_W   = 7;

    // Operation codes carried on the op field.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Per-cycle commands broadcast from the controller to every cell.
    typedef struct packed {
        logic cmp;   // compare stored key with the incoming key
        logic ins;   // open a gap at the insert position and drop the key in
        logic del;   // close the gap over the deleted key
    } cell_ctl_t;

endpackage

@@ sv/sus_cell.sv @@
module sus_cell
    import sus_pkg::*;
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic                     occ,
    input  logic signed [KEY_W-1:0]  cmp_key,
    input  logic signed [KEY_W-1:0]  ins_key,
    input  logic signed [KEY_W-1:0]  left_key,
    input  logic                     left_lt,
    input  logic signed [KEY_W-1:0]  right_key,
    output logic signed [KEY_W-1:0]  key_q,
    output logic                     lt_q,
    output logic                     eq_q
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    lt_reg;
    logic                    eq_reg;

    // A cell whose key is below the new key keeps it. Above that point an
    // insert shifts everything up by one cell and a delete shifts down by one.
    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins && !lt_reg)
        begin
            key_next = left_lt ? ins_key : left_key;
        end
        else if (ctl.del && !lt_reg)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (ctl.cmp)
        begin
            lt_reg <= occ && (key_reg < cmp_key);
            eq_reg <= occ && (key_reg == cmp_key);
        end
    end

    assign key_q = key_reg;
    assign lt_q  = lt_reg;
    assign eq_q  = eq_reg;

endmodule

@@ sv/sorted_unique_key_set_top.sv @@
// Sorted set of up to TABLE_DEPTH distinct signed 32-bit keys, kept in ascending
// order in a row of cells. Each input transfer either inserts (op = 0) or deletes
// (op = 1) one key and produces exactly one output transfer that reports whether
// the set changed, whether an insert was refused because the table was full, and
// the number of stored keys after the operation. When an item is accepted every
// cell compares its key with the incoming one, and in the update state all cells
// shift by one place at once to open or close a gap while the result is loaded
// into the output register. No new item is accepted until that update is done;
// the update waits only while a previous result is still held in the output
// register and the output side is stalling. Keys need no clearing after reset:
// only cells below the current count are ever compared or reported.
module sorted_unique_key_set_top
    import sus_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic signed [KEY_W-1:0]     key,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        changed,
    output logic                        full_refused,
    output logic [OUT_CNT_W-1:0]        entry_count
);

    typedef enum logic {ST_IDLE, ST_UPD} state_t;

    state_t                   state_reg;
    logic                     op_reg;
    logic signed [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     changed_reg;
    logic                     refused_reg;
    logic [OUT_CNT_W-1:0]     entry_count_reg;

    cell_ctl_t                ctl;
    logic                     in_fire;
    logic                     commit;
    logic                     present;
    logic                     full;
    logic                     do_ins;
    logic                     do_del;

    logic signed [KEY_W-1:0]  cell_key [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   lt_vec;
    logic [TABLE_DEPTH-1:0]   eq_vec;
    logic [TABLE_DEPTH-1:0]   occ_vec;

    // Input side is open only between items.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;

    // The update may proceed once the output register is free or being drained.
    assign commit  = (state_reg == ST_UPD) && (!out_valid_reg || !out_stall);
    assign present = |eq_vec;
    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign do_ins  = commit && (op_reg == OP_INSERT) && !present && !full;
    assign do_del  = commit && (op_reg == OP_DELETE) && present;

    assign ctl.cmp = in_fire;
    assign ctl.ins = do_ins;
    assign ctl.del = do_del;

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // The row of cells. Cell 0 sees an always-lower left neighbor so that it
    // takes the new key when the insert position is the very front; the last
    // cell feeds back its own key, which is out of range after a delete.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] left_key;
        logic                    left_lt;
        logic signed [KEY_W-1:0] right_key;

        assign occ_vec[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_key = key_reg;
            assign left_lt  = 1'b1;
        end
        else
        begin : g_mid
            assign left_key = cell_key[i-1];
            assign left_lt  = lt_vec[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign right_key = cell_key[i];
        end
        else
        begin : g_body
            assign right_key = cell_key[i+1];
        end

        sus_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occ       (occ_vec[i]),
            .cmp_key   (key),
            .ins_key   (key_reg),
            .left_key  (left_key),
            .left_lt   (left_lt),
            .right_key (right_key),
            .key_q     (cell_key[i]),
            .lt_q      (lt_vec[i]),
            .eq_q      (eq_vec[i])
        );
    end

    // Controller state, item registers, key count and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_INSERT;
            key_reg         <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            changed_reg     <= 1'b0;
            refused_reg     <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            // A result drained in the same cycle as a commit is replaced by the
            // new one, which the commit branch below marks valid.
            if (out_valid_reg && !out_stall && !commit)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg    <= op;
                        key_reg   <= key;
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    if (commit)
                    begin
                        count_reg       <= count_next;
                        out_valid_reg   <= 1'b1;
                        changed_reg     <= do_ins || do_del;
                        refused_reg     <= (op_reg == OP_INSERT) && !present && full;
                        entry_count_reg <= OUT_CNT_W'(count_next);
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign changed      = changed_reg;
    assign full_refused = refused_reg;
    assign entry_count  = entry_count_reg;

`ifndef SYNTHESIS
    // Stored keys are distinct, so at most one cell can match.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> $onehot0(eq_vec))
        else $error("more than one cell matched the key");

    // The count never passes the table capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("key count exceeds table depth");

    // A committed update always leaves a result waiting and frees the input side.
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("update did not produce a result");

    // A result never reports both a change and a refusal.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(changed_reg && refused_reg))
        else $error("changed and full_refused both set");
`endif

endmodule
